// ===== rtl/core/sbt_pkg.sv =====
package sbt_pkg;

  localparam int CoordW = 24;
  localparam int DiffW = 25;
  localparam int FtW = 16;
  localparam int TimeW = 17;
  localparam int QuoW = 16;
  localparam int DenW = DiffW + FtW;
  localparam int RemW = DenW + 1;
  localparam logic [TimeW-1:0] NoHit = 17'h10000;
  localparam logic [FtW-1:0] FrameTimeReset = 16'd1092;

  typedef struct packed {
    logic signed [CoordW-1:0] a_min_x;
    logic signed [CoordW-1:0] a_min_y;
    logic signed [CoordW-1:0] a_max_x;
    logic signed [CoordW-1:0] a_max_y;
    logic signed [CoordW-1:0] a_vel_x;
    logic signed [CoordW-1:0] a_vel_y;
    logic signed [CoordW-1:0] b_min_x;
    logic signed [CoordW-1:0] b_min_y;
    logic signed [CoordW-1:0] b_max_x;
    logic signed [CoordW-1:0] b_max_y;
    logic signed [CoordW-1:0] b_vel_x;
    logic signed [CoordW-1:0] b_vel_y;
  } sbt_in_t;

  typedef struct packed {
    logic [TimeW-1:0] impact_time;
    logic hit;
  } sbt_out_t;

  // Work carried down the divider chain: numerator remainder, divisor, quotient.
  typedef struct packed {
    logic valid;
    logic done;
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } sbt_cell_t;

endpackage

// ===== rtl/core/swept_box_time_of_impact.sv =====
// Swept 2D box time of impact.
// The input channel (in_valid/in_ready/in_data) carries one box pair with
// velocities per transfer; the output channel (out_valid/out_ready/out_data)
// returns one impact time in Q0.16 and a hit flag per input, in order.
// The frame duration is written with cfg_we/cfg_data; the user must write it while the block is idle (not enforced).
// The pipeline holds six front-end stages of differences, cross products
// and checks, then a row of sixteen restoring-divide cells, one quotient bit
// per cell, and an output register.
// Throughput is one pair per cycle when not stalled. The whole pipeline advances together;
// a stalled receiver holds the output register and freezes every stage,
// so in_ready follows out_ready when the output register is full.
// Reset clears the valid shift register and out_valid and returns the frame duration to 1092.
// A result of 65536 means no contact within the frame and hit low.
module swept_box_time_of_impact (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sbt_pkg::sbt_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output sbt_pkg::sbt_out_t out_data,
  input  logic cfg_we,
  input  logic [sbt_pkg::FtW-1:0] cfg_data
);
  import sbt_pkg::*;

  localparam int Stages = 22;

  logic [FtW-1:0] frame_dur;
  logic en;
  logic [Stages-1:0] vpipe;
  sbt_cell_t chain [QuoW+1];
  sbt_cell_t last;
  logic [TimeW-1:0] result_time;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_dur <= FrameTimeReset;
    end else if (cfg_we) begin
      frame_dur <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vpipe <= {vpipe[Stages-2:0], in_valid};
      out_valid <= vpipe[Stages-1];
    end
  end

  sbt_front u_front (
    .clk(clk), .en(en), .in_item(in_data), .frame_dur(frame_dur),
    .cell_out(chain[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    sbt_div_cell u_cell (.clk(clk), .en(en), .cell_in(chain[i]), .cell_out(chain[i+1]));
  end

  assign last = chain[QuoW];
  assign result_time = (last.done && last.rem == '0 && last.quo == '0 &&
                        last.den == '1) ? NoHit : TimeW'(last.quo);

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.impact_time <= result_time;
      out_data.hit <= (result_time != NoHit);
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid);
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hit == (out_data.impact_time != NoHit)));
  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vpipe));

endmodule

// ===== rtl/core/sbt_front.sv =====
module sbt_front (
  input  logic clk,
  input  logic en,
  input  sbt_pkg::sbt_in_t in_item,
  input  logic [sbt_pkg::FtW-1:0] frame_dur,
  output sbt_pkg::sbt_cell_t cell_out
);
  import sbt_pkg::*;

  // Stage 1: differences.
  logic signed [DiffW-1:0] dvx, dvy, lox, hix, loy, hiy;
  logic v1;
  logic [FtW-1:0] ft1;

  // Stage 2: per-axis slab numerators and denominators (den non-negative).
  logic signed [DiffW:0] ex_n, lx_n, ey_n, ly_n;
  logic [DiffW-1:0] dx, dy;
  logic mx, my, early_no, v2;
  logic [FtW-1:0] ft2;

  // Stage 3: cross products for the axis comparisons.
  logic signed [2*DiffW+1:0] pe_x, pe_y, pl_x, pl_y;
  logic signed [DiffW:0] ex3, lx3, ey3, ly3;
  logic [DiffW-1:0] dx3, dy3;
  logic mx3, my3, no3, v3;
  logic [FtW-1:0] ft3;

  // Stage 4: selected entry and exit.
  logic signed [DiffW:0] tin_n, tout_n;
  logic [DiffW-1:0] tin_d, tout_d;
  logic tout_inf, no4, v4;
  logic [FtW-1:0] ft4;

  // Stage 5: final checks products.
  logic signed [2*DiffW+1:0] p_a, p_b;
  logic signed [DiffW+FtW+17:0] lhs, rhs;
  logic signed [DiffW:0] tin5, tout5;
  logic [DiffW-1:0] tin_d5;
  logic tout_inf5, no5, v5;
  logic [FtW-1:0] ft5;

  logic signed [DiffW:0] n1x, n2x, n1y, n2y;
  logic miss;
  logic nohit;
  logic [DenW-1:0] den_w;

  always_ff @(posedge clk) begin
    if (en) begin
      v1 <= 1'b1;
      ft1 <= frame_dur;
      dvx <= DiffW'(in_item.a_vel_x) - DiffW'(in_item.b_vel_x);
      dvy <= DiffW'(in_item.a_vel_y) - DiffW'(in_item.b_vel_y);
      lox <= DiffW'(in_item.b_min_x) - DiffW'(in_item.a_max_x);
      hix <= DiffW'(in_item.b_max_x) - DiffW'(in_item.a_min_x);
      loy <= DiffW'(in_item.b_min_y) - DiffW'(in_item.a_max_y);
      hiy <= DiffW'(in_item.b_max_y) - DiffW'(in_item.a_min_y);
    end
  end

  always_comb begin
    n1x = dvx[DiffW-1] ? -(DiffW+1)'(lox) : (DiffW+1)'(lox);
    n2x = dvx[DiffW-1] ? -(DiffW+1)'(hix) : (DiffW+1)'(hix);
    n1y = dvy[DiffW-1] ? -(DiffW+1)'(loy) : (DiffW+1)'(loy);
    n2y = dvy[DiffW-1] ? -(DiffW+1)'(hiy) : (DiffW+1)'(hiy);
    miss = ((dvx == '0) && (lox > 0 || hix < 0)) || ((dvy == '0) && (loy > 0 || hiy < 0));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2 <= v1;
      ft2 <= ft1;
      mx <= (dvx != '0);
      my <= (dvy != '0);
      dx <= dvx[DiffW-1] ? -dvx : dvx;
      dy <= dvy[DiffW-1] ? -dvy : dvy;
      ex_n <= (n1x < n2x) ? n1x : n2x;
      lx_n <= (n1x < n2x) ? n2x : n1x;
      ey_n <= (n1y < n2y) ? n1y : n2y;
      ly_n <= (n1y < n2y) ? n2y : n1y;
      early_no <= (ft1 == '0) || ((dvx == '0) && (dvy == '0)) ||
                  (lox < 0 && hix > 0 && loy < 0 && hiy > 0) || miss;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v3 <= v2;
      ft3 <= ft2;
      pe_x <= ex_n * $signed({1'b0, dy});
      pe_y <= ey_n * $signed({1'b0, dx});
      pl_x <= lx_n * $signed({1'b0, dy});
      pl_y <= ly_n * $signed({1'b0, dx});
      ex3 <= ex_n; lx3 <= lx_n; ey3 <= ey_n; ly3 <= ly_n;
      dx3 <= dx; dy3 <= dy; mx3 <= mx; my3 <= my; no3 <= early_no;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v4 <= v3;
      ft4 <= ft3;
      no4 <= no3;
      tout_inf <= !(mx3 || my3);
      if (!mx3) begin
        tin_n <= ey3; tin_d <= dy3; tout_n <= ly3; tout_d <= dy3;
      end else if (!my3) begin
        tin_n <= ex3; tin_d <= dx3; tout_n <= lx3; tout_d <= dx3;
      end else begin
        if (pe_x < pe_y) begin
          tin_n <= ey3; tin_d <= dy3;
        end else begin
          tin_n <= ex3; tin_d <= dx3;
        end
        if (pl_x < pl_y) begin
          tout_n <= lx3; tout_d <= dx3;
        end else begin
          tout_n <= ly3; tout_d <= dy3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v5 <= v4;
      ft5 <= ft4;
      no5 <= no4;
      tout_inf5 <= tout_inf;
      tin5 <= tin_n;
      tout5 <= tout_n;
      tin_d5 <= tin_d;
      p_a <= tout_n * $signed({1'b0, tin_d});
      p_b <= tin_n * $signed({1'b0, tout_d});
      lhs <= (DiffW+FtW+18)'(tin_n) <<< 16;
      rhs <= $signed({1'b0, tin_d}) * $signed({1'b0, ft4});
    end
  end

  always_comb begin
    nohit = no5 || !(lhs < rhs) ||
            (!tout_inf5 && ((p_a < p_b) || (tout5 <= 0)));
    den_w = DenW'(tin_d5) * DenW'(ft5);
  end

  // A miss is marked by an all-ones divisor, which no real divisor reaches.
  always_ff @(posedge clk) begin
    if (en) begin
      cell_out.valid <= v5;
      cell_out.done <= nohit || (tin5 <= 0);
      cell_out.quo <= '0;
      cell_out.den <= nohit ? '1 : den_w;
      cell_out.rem <= (nohit || tin5 <= 0) ? '0 : RemW'({tin5[DiffW-1:0], 16'b0});
    end
  end

endmodule

// ===== rtl/core/sbt_div_cell.sv =====
module sbt_div_cell (
  input  logic clk,
  input  logic en,
  input  sbt_pkg::sbt_cell_t cell_in,
  output sbt_pkg::sbt_cell_t cell_out
);
  import sbt_pkg::*;

  logic [RemW:0] shifted;
  logic take;

  always_comb begin
    shifted = {cell_in.rem, 1'b0};
    take = !cell_in.done && (shifted >= (RemW+1)'(cell_in.den));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out.valid <= cell_in.valid;
      cell_out.done <= cell_in.done;
      cell_out.den <= cell_in.den;
      cell_out.quo <= {cell_in.quo[QuoW-2:0], take};
      cell_out.rem <= take ? RemW'(shifted - (RemW+1)'(cell_in.den)) : RemW'(shifted);
    end
  end

endmodule
